>>> hdl/e2q_pkg.sv
// ============================================================================
// e2q_pkg: shared types and constants for the Euler to quaternion unit
// Holds the fixed-point constants, the CORDIC arctangent table and the
// pipeline record that travels through the chain of rotation cells.
// ============================================================================
`default_nettype none

package e2q_pkg;

    localparam int CORDIC_STEPS = 24;
    localparam int ATAN_COUNT   = 30;
    localparam int STEP_W       = 5;    // bits of a rotation step index
    localparam int CW           = 34;   // CORDIC datapath width, Q3.30 plus guard

    localparam logic signed [31:0] ANGLE_LIMIT  = 32'sd1509949440;
    localparam logic signed [31:0] QUARTER_TURN = 32'sd754974720;
    localparam logic signed [31:0] HALF_TURN    = 32'sd1509949440;
    localparam logic [33:0]        RAD_C        = 34'd9595049034;
    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [31:0] ONE_Q30      = 32'sd1073741824;

    typedef logic signed [CW-1:0] cval_t;

    // One angle inside the CORDIC chain.
    typedef struct packed {
        cval_t x;
        cval_t y;
        cval_t z;
        logic  flip;
    } rot_t;

    // All three angles of one request.
    typedef struct packed {
        logic valid;
        rot_t ax;
        rot_t ay;
        rot_t az;
    } stage_t;

    function automatic cval_t atan_q30(input int idx);
        cval_t t;
        case (idx)
            0: t = 34'sd843314857;  1: t = 34'sd497837829;
            2: t = 34'sd263043837;  3: t = 34'sd133525159;
            4: t = 34'sd67021687;   5: t = 34'sd33543516;
            6: t = 34'sd16775851;   7: t = 34'sd8388437;
            8: t = 34'sd4194283;    9: t = 34'sd2097149;
            default: t = cval_t'(34'sd1 <<< (30 - idx));
        endcase
        return t;
    endfunction

endpackage

`default_nettype wire

>>> hdl/euler_to_quaternion_unit.sv
// ============================================================================
// euler_to_quaternion_unit: Euler angles to unit quaternion
// Pipelined converter: angle preparation, a chain of CORDIC cells and
// product stages, with one global stall.
// ============================================================================
// The unit accepts one request per clock while s_tready is high and returns
// one quaternion per request, in order. A request passes through 2 preparation
// stages, one cell per CORDIC iteration, 3 product stages and the output
// register. The whole pipeline advances whenever the output register is
// empty or being read, so throughput is one request per cycle without stalls.
`default_nettype none

module euler_to_quaternion_unit (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // angle_x_deg [31:0], angle_y_deg [63:32], angle_z_deg [95:64]
    input  wire logic [95:0]  s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // quat_w [31:0], quat_x [63:32], quat_y [95:64], quat_z [127:96]
    output logic [127:0]      m_tdata
);
    import e2q_pkg::*;

    localparam int LAT = CORDIC_STEPS + 5;

    logic             en;
    logic [LAT-1:0]   vpipe_reg;
    stage_t           chain [0:CORDIC_STEPS];
    logic signed [31:0] qw, qx, qy, qz;

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // Valid tracking along the whole pipeline.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vpipe_reg <= '0;
        end else if (en) begin
            vpipe_reg <= {vpipe_reg[LAT-2:0], s_tvalid};
        end
    end

    e2q_prep u_prep_x (.aclk(aclk), .en(en), .angle(s_tdata[31:0]),  .rot(chain[0].ax));
    e2q_prep u_prep_y (.aclk(aclk), .en(en), .angle(s_tdata[63:32]), .rot(chain[0].ay));
    e2q_prep u_prep_z (.aclk(aclk), .en(en), .angle(s_tdata[95:64]), .rot(chain[0].az));
    assign chain[0].valid = vpipe_reg[1];

    // Chain of CORDIC rotation cells.
    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
        e2q_cell u_cell (
            .aclk(aclk), .aresetn(aresetn), .en(en), .step(STEP_W'(i)),
            .din(chain[i]), .dout(chain[i+1])
        );
    end

    e2q_combine u_comb (
        .aclk(aclk), .en(en), .din(chain[CORDIC_STEPS]),
        .qw(qw), .qx(qx), .qy(qy), .qz(qz)
    );

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid <= 1'b0;
        end else if (en) begin
            m_tvalid <= vpipe_reg[LAT-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata <= {qz, qy, qx, qw};
        end
    end

`ifndef NO_ASSERTIONS
    a_valid_match: assert property (@(posedge aclk) disable iff (!aresetn)
        vpipe_reg[CORDIC_STEPS+1] == chain[CORDIC_STEPS].valid)
        else $error("cell chain valid out of step");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[31:0]) <= ONE_Q30 &&
                      $signed(m_tdata[31:0]) >= -ONE_Q30))
        else $error("quat_w out of unit range");
`endif

endmodule

`default_nettype wire

>>> hdl/e2q_prep.sv
// ============================================================================
// e2q_prep: half-angle range reduction and degree to radian conversion
// Two register stages: saturate and fold into a right angle, then multiply
// the magnitude by pi/180 and round.
// ============================================================================
`default_nettype none

module e2q_prep (
    input  wire logic                aclk,
    input  wire logic                en,
    input  wire logic signed [31:0]  angle,
    output e2q_pkg::rot_t            rot
);
    import e2q_pkg::*;

    logic signed [31:0] h_sat;
    logic signed [31:0] h_fold;
    logic               flip_c;
    logic [30:0]        mag_reg, mag_next;
    logic               neg_reg, neg_next;
    logic               flip_reg, flip_next;
    logic [64:0]        prod;
    logic [32:0]        r_mag;

    // Saturate and fold the half angle (the input read as Q9.23).
    always_comb begin
        h_sat = angle;
        if (angle > ANGLE_LIMIT) h_sat = ANGLE_LIMIT;
        if (angle < -ANGLE_LIMIT) h_sat = -ANGLE_LIMIT;
        flip_c = 1'b0;
        h_fold = h_sat;
        if (h_sat > QUARTER_TURN) begin
            h_fold = h_sat - HALF_TURN;
            flip_c = 1'b1;
        end else if (h_sat < -QUARTER_TURN) begin
            h_fold = h_sat + HALF_TURN;
            flip_c = 1'b1;
        end
        neg_next  = h_fold[31];
        mag_next  = h_fold[31] ? 31'(-h_fold) : h_fold[30:0];
        flip_next = flip_c;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mag_reg  <= mag_next;
            neg_reg  <= neg_next;
            flip_reg <= flip_next;
        end
    end

    // Radians in Q30, rounded half away from zero.
    assign prod  = 65'({34'd0, mag_reg} * {31'd0, RAD_C}) + 65'd2147483648;
    assign r_mag = prod[64:32];

    always_ff @(posedge aclk) begin
        if (en) begin
            rot.x    <= CORDIC_GAIN;
            rot.y    <= '0;
            rot.z    <= neg_reg ? -cval_t'(r_mag) : cval_t'(r_mag);
            rot.flip <= flip_reg;
        end
    end

endmodule

`default_nettype wire

>>> hdl/e2q_cell.sv
// ============================================================================
// e2q_cell: one CORDIC rotation cell
// Applies one micro-rotation of a fixed index to all three angles and hands
// the result to the next cell.
// ============================================================================
`default_nettype none

module e2q_cell (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      en,
    input  wire logic [e2q_pkg::STEP_W-1:0] step,
    input  e2q_pkg::stage_t                din,
    output e2q_pkg::stage_t                dout
);
    import e2q_pkg::*;

    function automatic rot_t rotate(input rot_t r, input logic [STEP_W-1:0] s);
        rot_t o;
        cval_t dx, dy;
        dx = r.y >>> s;
        dy = r.x >>> s;
        o = r;
        if (!r.z[CW-1]) begin
            o.x = r.x - dx;
            o.y = r.y + dy;
            o.z = r.z - atan_q30(int'(s));
        end else begin
            o.x = r.x + dx;
            o.y = r.y - dy;
            o.z = r.z + atan_q30(int'(s));
        end
        return o;
    endfunction

    // Valid flag and one micro-rotation per angle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dout.valid <= 1'b0;
        end else if (en) begin
            dout.valid <= din.valid;
        end
        if (en) begin
            dout.ax <= rotate(din.ax, step);
            dout.ay <= rotate(din.ay, step);
            dout.az <= rotate(din.az, step);
        end
    end

endmodule

`default_nettype wire

>>> hdl/e2q_combine.sv
// ============================================================================
// e2q_combine: triple products and final sums
// Stage 1 forms pair products, stage 2 the triple products, stage 3 the
// sums with saturation to unit range.
// ============================================================================
`default_nettype none

module e2q_combine (
    input  wire logic               aclk,
    input  wire logic               en,
    input  e2q_pkg::stage_t         din,
    output logic signed [31:0]      qw,
    output logic signed [31:0]      qx,
    output logic signed [31:0]      qy,
    output logic signed [31:0]      qz
);
    import e2q_pkg::*;

    function automatic cval_t qmul(input cval_t a, input cval_t b);
        logic signed [2*CW-1:0] p;
        p = (2*CW)'(a) * (2*CW)'(b) + (2*CW)'(64'sd536870912);
        return cval_t'(p >>> 30);
    endfunction

    function automatic logic signed [31:0] sat(input logic signed [CW:0] v);
        logic signed [31:0] o;
        if (v > (CW+1)'(ONE_Q30)) o = ONE_Q30;
        else if (v < -(CW+1)'(ONE_Q30)) o = -ONE_Q30;
        else o = v[31:0];
        return o;
    endfunction

    cval_t cx, sx, cy, sy, cz, sz;
    cval_t cz_reg, sz_reg;
    cval_t cxcy_reg, sxsy_reg, sxcy_reg, cxsy_reg;
    cval_t t0_reg, t1_reg, t2_reg, t3_reg, t4_reg, t5_reg, t6_reg, t7_reg;

    always_comb begin
        cx = din.ax.flip ? -din.ax.x : din.ax.x;
        sx = din.ax.flip ? -din.ax.y : din.ax.y;
        cy = din.ay.flip ? -din.ay.x : din.ay.x;
        sy = din.ay.flip ? -din.ay.y : din.ay.y;
        cz = din.az.flip ? -din.az.x : din.az.x;
        sz = din.az.flip ? -din.az.y : din.az.y;
    end

    // Pair products of the x and y terms.
    always_ff @(posedge aclk) begin
        if (en) begin
            cxcy_reg <= qmul(cx, cy);
            sxsy_reg <= qmul(sx, sy);
            sxcy_reg <= qmul(sx, cy);
            cxsy_reg <= qmul(cx, sy);
            cz_reg   <= cz;
            sz_reg   <= sz;
        end
    end

    // Triple products.
    always_ff @(posedge aclk) begin
        if (en) begin
            t0_reg <= qmul(cxcy_reg, cz_reg);
            t1_reg <= qmul(sxsy_reg, sz_reg);
            t2_reg <= qmul(sxcy_reg, cz_reg);
            t3_reg <= qmul(cxsy_reg, sz_reg);
            t4_reg <= qmul(cxsy_reg, cz_reg);
            t5_reg <= qmul(sxcy_reg, sz_reg);
            t6_reg <= qmul(cxcy_reg, sz_reg);
            t7_reg <= qmul(sxsy_reg, cz_reg);
        end
    end

    // Sums and saturation.
    always_ff @(posedge aclk) begin
        if (en) begin
            qw <= sat((CW+1)'(t0_reg) + (CW+1)'(t1_reg));
            qx <= sat((CW+1)'(t2_reg) - (CW+1)'(t3_reg));
            qy <= sat((CW+1)'(t4_reg) + (CW+1)'(t5_reg));
            qz <= sat((CW+1)'(t6_reg) - (CW+1)'(t7_reg));
        end
    end

endmodule

`default_nettype wire
